/* rtl/core/spq_pkg.sv */
// Shared types, sizes and codes of the sorted priority queue.
// Depends on nothing; imported by the queue core and by its port checker.
`default_nettype none

package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int ID_BITS = 8;
   localparam int AW      = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   localparam int ID_W        = 8;
   localparam int KEY_W       = 32;
   localparam int OCC_W       = 5;
   localparam int STAT_W      = 2;
   localparam int OP_W        = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [OP_W-1:0] {
      OP_POP    = 2'd0,
      OP_SORTED = 2'd1,
      OP_APPEND = 2'd2,
      OP_REMOVE = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_CAP,
      S_SCAN,
      S_INS,
      S_DEL,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [ID_BITS-1:0] id;
   } entry_type;

   // True when a is strictly smaller than b in (key, id) order.
   function automatic logic less_than(entry_type a, entry_type b);
      return (a.key < b.key) || ((a.key == b.key) && (a.id < b.id));
   endfunction

endpackage

`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
// Sorted priority queue core: entry memory, scan and shift sequencer, result register.
// Depends on spq_pkg for sizes, entry type, opcodes and status codes.
//
// Requests arrive on req_ as one beat each: the opcode in req_tuser, the requester
// id and key in req_tdata. Every request gives exactly one response beat on rsp_,
// carrying the status in rsp_tuser and the popped id, popped key and occupancy in
// rsp_tdata. Requests are handled one at a time.
// All entries live in one memory with a single write port and a registered read
// port, so entries are read and moved one at a time. Pop on an empty queue, any
// full-queue insert, append, sorted insert into an empty queue and a remove on an
// empty queue go straight to the response without a scan or shift.
// Pop shifts the remaining entries forward. Sorted insert and remove scan from the
// front (one entry per cycle) and then shift the tail.
// A new request is taken while an earlier response still waits in the output
// register; if the receiver stalls, the finished next response waits inside the
// block and no further request is taken. Reset empties the queue and drops any
// pending response; the entry memory itself is not cleared.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [REQ_TDATA_W-1:0]  req_tdata,   // requester_id [7:0], key [39:8]
   input  wire [OP_W-1:0]         req_tuser,   // opcode [1:0]
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // popped_id [7:0], popped_key [39:8],
                                               // occupancy [44:40], zero above
   output logic [STAT_W-1:0]      rsp_tuser    // status [1:0]
);

   entry_type entry_mem [DEPTH];
   entry_type rd_entry_ff;

   state_type  state_ff, state_in;
   opcode_type op_ff, op_in;
   entry_type  new_ff, new_in;
   entry_type  pop_ff, pop_in;
   status_type status_ff, status_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] nxt_ff, nxt_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [AW-1:0]    chk_ff, chk_in;
   logic [AW-1:0]    wdst_ff, wdst_in;
   logic             pend_ff, pend_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   entry_type        rsp_pop_ff, rsp_pop_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [AW-1:0] mem_raddr;

   opcode_type       req_op;
   entry_type        req_entry;
   logic             req_fire;
   logic             cnt_zero, cnt_full;
   logic             fwd_issue, ins_issue;
   logic             scan_hit, scan_end;
   logic             rsp_free;
   logic [CNT_W-1:0] nxt_inc, nxt_dec;

   assign req_op       = opcode_type'(req_tuser);
   assign req_entry.id  = req_tdata[ID_BITS-1:0];
   assign req_entry.key = req_tdata[ID_W +: KEY_W];
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;

   assign cnt_zero  = (cnt_ff == '0);
   assign cnt_full  = (cnt_ff == CNT_W'(DEPTH));
   assign nxt_inc   = nxt_ff + CNT_W'(1);
   assign nxt_dec   = nxt_ff - CNT_W'(1);
   assign fwd_issue = (nxt_ff < cnt_ff);
   assign ins_issue = (nxt_ff > pos_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      scan_hit = 1'b0;
      if (pend_ff) begin
         if (op_ff == OP_REMOVE) begin
            scan_hit = (rd_entry_ff.id == new_ff.id);
         end else if (chk_ff == '0) begin
            scan_hit = less_than(new_ff, rd_entry_ff);
         end else begin
            scan_hit = !less_than(rd_entry_ff, new_ff);
         end
      end
   end

   assign scan_end = !pend_ff && !fwd_issue;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_POP:    state_in = cnt_zero ? S_FIN : S_POP_CAP;
                  OP_SORTED: state_in = (cnt_full || cnt_zero) ? S_FIN : S_SCAN;
                  OP_APPEND: state_in = S_FIN;
                  OP_REMOVE: state_in = cnt_zero ? S_FIN : S_SCAN;
                  default:   state_in = S_FIN;
               endcase
            end
         end
         S_POP_CAP: state_in = S_DEL;
         S_SCAN: begin
            if (scan_hit) begin
               state_in = (op_ff == OP_REMOVE) ? S_DEL : S_INS;
            end else if (scan_end) begin
               state_in = (op_ff == OP_REMOVE) ? S_FIN : S_INS;
            end
         end
         S_INS: begin
            if (!ins_issue && !pend_ff) begin
               state_in = S_FIN;
            end
         end
         S_DEL: begin
            if (!fwd_issue && !pend_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      op_in     = op_ff;
      new_in    = new_ff;
      pop_in    = pop_ff;
      status_in = status_ff;
      cnt_in    = cnt_ff;
      nxt_in    = nxt_ff;
      pos_in    = pos_ff;
      chk_in    = chk_ff;
      wdst_in   = wdst_ff;
      pend_in   = pend_ff;
      mem_we    = 1'b0;
      mem_waddr = wdst_ff;
      mem_wdata = rd_entry_ff;
      mem_raddr = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pop_in    = rsp_pop_ff;
      rsp_occ_in    = rsp_occ_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_op;
               new_in    = req_entry;
               pop_in    = '0;
               status_in = STAT_DONE;
               nxt_in    = '0;
               pend_in   = 1'b0;
               case (req_op)
                  OP_POP: begin
                     if (cnt_zero) begin
                        status_in = STAT_EMPTY;
                     end
                  end
                  OP_SORTED, OP_APPEND: begin
                     if (cnt_full) begin
                        status_in = STAT_FULL;
                     end else if (req_op == OP_APPEND || cnt_zero) begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_ff[AW-1:0];
                        mem_wdata = req_entry;
                        cnt_in    = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (cnt_zero) begin
                        status_in = STAT_NOT_FOUND;
                     end
                  end
                  default: status_in = STAT_DONE;
               endcase
            end
         end
         S_POP_CAP: begin
            pop_in  = rd_entry_ff;
            nxt_in  = CNT_W'(1);
            pend_in = 1'b0;
         end
         S_SCAN: begin
            mem_raddr = nxt_ff[AW-1:0];
            if (scan_hit) begin
               pos_in  = CNT_W'(chk_ff);
               pend_in = 1'b0;
               nxt_in  = (op_ff == OP_REMOVE) ? CNT_W'(chk_ff) + CNT_W'(1) : cnt_ff;
            end else if (scan_end) begin
               if (op_ff == OP_REMOVE) begin
                  status_in = STAT_NOT_FOUND;
               end
               pos_in = cnt_ff;
               nxt_in = cnt_ff;
            end else begin
               pend_in = fwd_issue;
               chk_in  = nxt_ff[AW-1:0];
               if (fwd_issue) begin
                  nxt_in = nxt_inc;
               end
            end
         end
         S_INS: begin
            mem_raddr = nxt_dec[AW-1:0];
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (ins_issue) begin
               wdst_in = nxt_ff[AW-1:0];
               pend_in = 1'b1;
               nxt_in  = nxt_dec;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_ff[AW-1:0];
                  mem_wdata = new_ff;
                  cnt_in    = cnt_ff + CNT_W'(1);
               end
            end
         end
         S_DEL: begin
            mem_raddr = nxt_ff[AW-1:0];
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (fwd_issue) begin
               wdst_in = nxt_dec[AW-1:0];
               pend_in = 1'b1;
               nxt_in  = nxt_inc;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pop_in    = pop_ff;
               rsp_occ_in    = OCC_W'(cnt_ff);
            end
         end
         default: pend_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_entry_ff <= entry_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      new_ff        <= new_in;
      pop_ff        <= pop_in;
      status_ff     <= status_in;
      nxt_ff        <= nxt_in;
      pos_ff        <= pos_in;
      chk_ff        <= chk_in;
      wdst_ff       <= wdst_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pop_ff    <= rsp_pop_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - OCC_W - KEY_W - ID_W)'(0), rsp_occ_ff,
                        rsp_pop_ff.key, ID_W'(rsp_pop_ff.id)};

endmodule

`default_nettype wire

/* rtl/core/spq_checker.sv */
// Port-level checker for the sorted priority queue, bound to its top level.
// Depends on spq_pkg for sizes and status codes.
`default_nettype none

module spq_checker
   import spq_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [RSP_TDATA_W-1:0] rsp_tdata,
   input wire [STAT_W-1:0]      rsp_tuser
);

   logic [OCC_W-1:0] occ;

   assign occ = rsp_tdata[ID_W + KEY_W +: OCC_W];

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response beat present right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ <= OCC_W'(DEPTH))
      else $error("occupancy above queue depth");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_EMPTY |-> occ == '0 && rsp_tdata[ID_W+KEY_W-1:0] == '0)
      else $error("empty status with entries or popped data");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_FULL |-> occ == OCC_W'(DEPTH))
      else $error("full status while queue not full");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the sorted priority queue: directed and random traffic on the
// request stream, with a built-in predictor of queue contents and response fields.
// Depends on spq_pkg and the sorted_priority_queue RTL only.
`default_nettype none

module testbench;
   import spq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      status_type       status;
      logic [ID_W-1:0]  popped_id;
      logic [KEY_W-1:0] popped_key;
      logic [OCC_W-1:0] occupancy;
   } response_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]        req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]      rsp_tuser;

   sorted_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Predicted queue contents, front at index 0.
   entry_type    queue_entries [DEPTH];
   int unsigned  queue_count = 0;
   response_type expected_rsp [$];

   int error_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int full_reached = 0;
   int burst_left = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int stall_mode_left = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic ranks_ahead(entry_type a, entry_type b);
      if (a.key != b.key)
         return a.key < b.key;
      return a.id < b.id;
   endfunction

   function automatic response_type queue_apply(opcode_type op, logic [ID_W-1:0] id,
                                                logic [KEY_W-1:0] key);
      response_type rsp;
      entry_type    fresh;
      int unsigned  pos;
      rsp.status     = STAT_DONE;
      rsp.popped_id  = '0;
      rsp.popped_key = '0;
      fresh.id  = id[ID_BITS-1:0];
      fresh.key = key;
      case (op)
         OP_POP: begin
            if (queue_count == 0) begin
               rsp.status = STAT_EMPTY;
            end else begin
               rsp.popped_id  = ID_W'(queue_entries[0].id);
               rsp.popped_key = queue_entries[0].key;
               for (int i = 0; i + 1 < queue_count; i++)
                  queue_entries[i] = queue_entries[i + 1];
               queue_count--;
            end
         end
         OP_SORTED, OP_APPEND: begin
            if (queue_count >= DEPTH) begin
               rsp.status = STAT_FULL;
            end else begin
               if (op == OP_APPEND) begin
                  pos = queue_count;
               end else if (queue_count == 0 || ranks_ahead(fresh, queue_entries[0])) begin
                  pos = 0;
               end else begin
                  pos = 1;
                  while (pos < queue_count && ranks_ahead(queue_entries[pos], fresh))
                     pos++;
               end
               for (int i = queue_count; i > pos; i--)
                  queue_entries[i] = queue_entries[i - 1];
               queue_entries[pos] = fresh;
               queue_count++;
            end
         end
         default: begin
            pos = queue_count;
            for (int i = 0; i < queue_count; i++) begin
               if (pos == queue_count && queue_entries[i].id == fresh.id)
                  pos = i;
            end
            if (pos == queue_count) begin
               rsp.status = STAT_NOT_FOUND;
            end else begin
               for (int i = pos; i + 1 < queue_count; i++)
                  queue_entries[i] = queue_entries[i + 1];
               queue_count--;
            end
         end
      endcase
      rsp.occupancy = OCC_W'(queue_count);
      return rsp;
   endfunction

   task automatic send_request(opcode_type op, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 15) == 0)
            gap = $urandom_range(20, 60);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {key, id};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rsp.push_back(queue_apply(op, id, key));
      if (queue_count == DEPTH)
         full_reached++;
      requests_sent++;
      burst_left--;
   endtask

   // Bias 0 leans toward filling, 1 toward draining, anything else is even.
   task automatic random_request(int bias);
      opcode_type       op;
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
      int               roll;
      roll = $urandom_range(0, 99);
      case (bias)
         0:       op = (roll < 15) ? OP_POP : (roll < 60) ? OP_SORTED :
                       (roll < 85) ? OP_APPEND : OP_REMOVE;
         1:       op = (roll < 40) ? OP_POP : (roll < 50) ? OP_SORTED :
                       (roll < 60) ? OP_APPEND : OP_REMOVE;
         default: op = opcode_type'(roll % 4);
      endcase
      roll = $urandom_range(0, 9);
      if (roll < 4 && queue_count > 0)
         id = ID_W'(queue_entries[$urandom_range(0, queue_count - 1)].id);
      else if (roll < 7)
         id = ID_W'($urandom_range(0, 7));
      else if (roll == 7)
         id = $urandom_range(0, 1) ? '1 : '0;
      else
         id = ID_W'($urandom_range(0, 255));
      roll = $urandom_range(0, 9);
      if (roll < 4)
         key = KEY_W'($urandom_range(0, 7));
      else if (roll < 6 && queue_count > 0)
         key = queue_entries[$urandom_range(0, queue_count - 1)].key;
      else if (roll == 6)
         key = $urandom_range(0, 1) ? '1 : '0;
      else
         key = $urandom;
      send_request(op, id, key);
   endtask

   task automatic check_response();
      response_type want;
      if (expected_rsp.size() == 0) begin
         $error("response beat with no request outstanding: tdata=%h tuser=%0d",
                rsp_tdata, rsp_tuser);
         error_count++;
      end else begin
         want = expected_rsp.pop_front();
         responses_checked++;
         status_seen[rsp_tuser]++;
         if (rsp_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_tuser);
            error_count++;
         end
         if (rsp_tdata[7:0] !== want.popped_id) begin
            $error("popped_id: expected %0d, got %0d", want.popped_id, rsp_tdata[7:0]);
            error_count++;
         end
         if (rsp_tdata[39:8] !== want.popped_key) begin
            $error("popped_key: expected %h, got %h", want.popped_key, rsp_tdata[39:8]);
            error_count++;
         end
         if (rsp_tdata[44:40] !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_tdata[44:40]);
            error_count++;
         end
         if (rsp_tdata[47:45] !== 3'b000) begin
            $error("tdata padding: expected 0, got %0d", rsp_tdata[47:45]);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_response();
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(8, 80);
         end
         stall_mode_left--;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= cycle_count[1];
         endcase
      end
   end

   task automatic test_empty_queue();
      send_request(OP_POP, 8'd0, 32'd0);
      send_request(OP_REMOVE, 8'd0, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 8'd255, 32'd0);
   endtask

   task automatic test_ordering_and_full();
      send_request(OP_SORTED, 8'd10, 32'd100);
      send_request(OP_SORTED, 8'd5, 32'd100);
      send_request(OP_SORTED, 8'd20, 32'd100);
      send_request(OP_SORTED, 8'd0, 32'd0);
      send_request(OP_SORTED, 8'd255, 32'hFFFF_FFFF);
      // An out-of-order tail left by append must not disturb the placement rule.
      send_request(OP_APPEND, 8'd7, 32'd1);
      send_request(OP_SORTED, 8'd9, 32'd50);
      send_request(OP_SORTED, 8'd1, 32'd0);
      send_request(OP_APPEND, 8'd0, 32'hFFFF_FFFF);
      while (queue_count < DEPTH)
         send_request(OP_SORTED, ID_W'($urandom_range(30, 90)), $urandom);
      send_request(OP_SORTED, 8'd3, 32'd2);
      send_request(OP_APPEND, 8'd4, 32'd2);
      send_request(OP_REMOVE, 8'd200, 32'd0);
      send_request(OP_REMOVE, 8'd0, 32'd0);
      send_request(OP_POP, 8'd0, 32'd0);
      send_request(OP_POP, 8'hFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_backpressure();
      hold_asked++;
      repeat (40) random_request(2);
   endtask

   task automatic test_random_traffic();
      int sent;
      int seg_len;
      int bias;
      sent = 0;
      while (sent < 1000) begin
         seg_len = $urandom_range(20, 80);
         bias = $urandom_range(0, 2);
         repeat (seg_len) begin
            random_request(bias);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_ordering_and_full();
      test_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests and checked %0d responses; queue full %0d times.",
               requests_sent, responses_checked, full_reached);
      $display("Statuses seen: done %0d, empty %0d, full %0d, not found %0d.",
               status_seen[STAT_DONE], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
               status_seen[STAT_NOT_FOUND]);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
